@@ hw/rtl/ldpr_pkg.sv @@
// Shared types, constants and reset values for the lens distortion remapper.
package ldpr_pkg;

    // Fraction bits of the normalized coordinate and coefficient format (Q4.28)
    localparam int unsigned Q_FRAC = 28;

    localparam int unsigned IMAGE_WIDTH_DEF  = 1920;
    localparam int unsigned IMAGE_HEIGHT_DEF = 1080;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_CENTER_COL = 3'd0,
        CFG_CENTER_ROW = 3'd1,
        CFG_FOCAL_LEN  = 3'd2,
        CFG_NORM_SCALE = 3'd3,
        CFG_RADIAL_K1  = 3'd4,
        CFG_RADIAL_K2  = 3'd5,
        CFG_TAN_P1     = 3'd6,
        CFG_TAN_P2     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [11:0] center_col;
        logic        [11:0] center_row;
        logic        [11:0] focal_length;
        logic        [23:0] norm_scale;
        logic signed [31:0] radial_k1;
        logic signed [31:0] radial_k2;
        logic signed [31:0] tangential_p1;
        logic signed [31:0] tangential_p2;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam cfg_t CFG_RESET = '{
        center_col:    12'd960,
        center_row:    12'd540,
        focal_length:  12'd470,
        norm_scale:    24'd71392,
        radial_k1:     -32'sd37580964,
        radial_k2:     32'sd3489661,
        tangential_p1: 32'sd46574,
        tangential_p2: 32'sd688269
    };

endpackage

@@ hw/rtl/ldpr_pipe.sv @@
// Twelve-stage fixed-point distortion datapath with per-stage valid and stall.
module ldpr_pipe #(
    parameter int unsigned IMAGE_WIDTH  = ldpr_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = ldpr_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ldpr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         src_col,
    input  logic [11:0]         src_row,
    input  ldpr_pkg::rgb_t      pix_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         dest_col,
    output logic [11:0]         dest_row,
    output ldpr_pkg::rgb_t      pix_out,
    output logic                in_bounds
);

    localparam int unsigned NSTG = 12;
    localparam int unsigned QF   = ldpr_pkg::Q_FRAC;

    localparam logic signed [47:0] F_ONE = 48'sd1 <<< QF;
    localparam logic signed [37:0] W_LIM = 38'(IMAGE_WIDTH);
    localparam logic signed [37:0] H_LIM = 38'(IMAGE_HEIGHT);

    // Saturate 16*p to the Q4.28 range
    function automatic logic signed [31:0] sat_q(input logic signed [36:0] p);
        logic [9:0] top;
        top = p[36:27];
        if (top == '0 || top == '1)
            sat_q = $signed({p[27:0], 4'b0000});
        else if (p[36])
            sat_q = 32'sh8000_0000;
        else
            sat_q = 32'sh7fff_ffff;
    endfunction

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;
    ldpr_pkg::rgb_t  pix_reg [NSTG];

    // stage 1
    logic signed [12:0] s1_dx, s1_dy;
    logic signed [36:0] s1_px_next, s1_py_next, s1_px_reg, s1_py_reg;
    // stage 2
    logic signed [31:0] s2_xn_reg, s2_yn_reg;
    // stage 3
    logic signed [63:0] s3_xx_full, s3_yy_full, s3_xy_full;
    logic        [34:0] s3_xx_reg, s3_yy_reg;
    logic signed [35:0] s3_xy_reg;
    logic signed [31:0] s3_xn_reg, s3_yn_reg;
    // stage 4
    logic        [35:0] s4_r_next, s4_r_reg;
    logic        [36:0] s4_rx_next, s4_ry_next, s4_rx_reg, s4_ry_reg;
    logic signed [35:0] s4_xy_reg;
    logic signed [31:0] s4_xn_reg, s4_yn_reg;
    // stage 5
    logic        [14:0] s5_hh_next, s5_hh_reg;
    logic        [34:0] s5_hl_next, s5_hl_reg;
    logic        [55:0] s5_ll_full;
    logic        [27:0] s5_ll_reg;
    logic signed [60:0] s5_k1l_full, s5_q1l_full, s5_q2l_full, s5_txl_full, s5_tyl_full;
    logic signed [40:0] s5_k1h_next, s5_k1h_reg;
    logic signed [32:0] s5_k1l_reg, s5_q1l_reg, s5_q2l_reg, s5_txl_reg, s5_tyl_reg;
    logic signed [39:0] s5_q1h_next, s5_q2h_next, s5_q1h_reg, s5_q2h_reg;
    logic signed [41:0] s5_txh_next, s5_tyh_next, s5_txh_reg, s5_tyh_reg;
    logic signed [31:0] s5_xn_reg, s5_yn_reg;
    // stage 6
    logic        [42:0] s6_r2_next, s6_r2_reg;
    logic signed [40:0] s6_rk1_sum;
    logic signed [39:0] s6_rk1_reg;
    logic signed [41:0] s6_tx_next, s6_ty_next, s6_tx_reg, s6_ty_reg;
    logic signed [31:0] s6_xn_reg, s6_yn_reg;
    // stage 7
    logic signed [47:0] s7_k2h_next, s7_k2h_reg;
    logic signed [60:0] s7_k2l_full;
    logic signed [32:0] s7_k2l_reg;
    logic signed [39:0] s7_rk1_reg;
    logic signed [41:0] s7_tx_reg, s7_ty_reg;
    logic signed [31:0] s7_xn_reg, s7_yn_reg;
    // stage 8
    logic signed [47:0] s8_f_next, s8_f_reg;
    logic signed [41:0] s8_tx_reg, s8_ty_reg;
    logic signed [31:0] s8_xn_reg, s8_yn_reg;
    // stage 9
    logic signed [51:0] s9_fxh_next, s9_fyh_next, s9_fxh_reg, s9_fyh_reg;
    logic signed [60:0] s9_fxl_full, s9_fyl_full;
    logic signed [32:0] s9_fxl_reg, s9_fyl_reg;
    logic signed [41:0] s9_tx_reg, s9_ty_reg;
    // stage 10
    logic signed [51:0] s10_xd_next, s10_yd_next, s10_xd_reg, s10_yd_reg;
    // stage 11
    logic signed [36:0] s11_xph_next, s11_yph_next, s11_xph_reg, s11_yph_reg;
    logic        [39:0] s11_xpl_next, s11_ypl_next, s11_xpl_reg, s11_ypl_reg;
    // stage 12
    logic signed [37:0] s12_vx, s12_vy;
    logic               s12_ok;
    logic        [11:0] dest_col_reg, dest_row_reg;
    logic               in_bounds_reg;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Colour rides along unchanged
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pix_reg[0] <= pix_in;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (en[k])
            begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        // offset from center times scale
        s1_dx      = $signed({1'b0, src_col}) - $signed({1'b0, cfg.center_col});
        s1_dy      = $signed({1'b0, src_row}) - $signed({1'b0, cfg.center_row});
        s1_px_next = s1_dx * $signed({1'b0, cfg.norm_scale});
        s1_py_next = s1_dy * $signed({1'b0, cfg.norm_scale});

        // squares and cross term
        s3_xx_full = s2_xn_reg * s2_xn_reg;
        s3_yy_full = s2_yn_reg * s2_yn_reg;
        s3_xy_full = s2_xn_reg * s2_yn_reg;

        // radius and tangential sums
        s4_r_next  = {1'b0, s3_xx_reg} + {1'b0, s3_yy_reg};
        s4_rx_next = 37'({s3_xx_reg, 1'b0}) + 37'(s3_xx_reg) + 37'(s3_yy_reg);
        s4_ry_next = 37'({s3_yy_reg, 1'b0}) + 37'(s3_yy_reg) + 37'(s3_xx_reg);

        // partial products split at the binary point
        s5_hh_next  = s4_r_reg[35:28] * s4_r_reg[35:28];
        s5_hl_next  = s4_r_reg[35:28] * s4_r_reg[27:0];
        s5_ll_full  = s4_r_reg[27:0] * s4_r_reg[27:0];
        s5_k1h_next = $signed({1'b0, s4_r_reg[35:28]}) * cfg.radial_k1;
        s5_k1l_full = $signed({1'b0, s4_r_reg[27:0]}) * cfg.radial_k1;
        s5_q1h_next = $signed(s4_xy_reg[35:28]) * cfg.tangential_p1;
        s5_q1l_full = $signed({1'b0, s4_xy_reg[27:0]}) * cfg.tangential_p1;
        s5_q2h_next = $signed(s4_xy_reg[35:28]) * cfg.tangential_p2;
        s5_q2l_full = $signed({1'b0, s4_xy_reg[27:0]}) * cfg.tangential_p2;
        s5_txh_next = $signed({1'b0, s4_rx_reg[36:28]}) * cfg.tangential_p2;
        s5_txl_full = $signed({1'b0, s4_rx_reg[27:0]}) * cfg.tangential_p2;
        s5_tyh_next = $signed({1'b0, s4_ry_reg[36:28]}) * cfg.tangential_p1;
        s5_tyl_full = $signed({1'b0, s4_ry_reg[27:0]}) * cfg.tangential_p1;

        // fold partials
        s6_r2_next = {s5_hh_reg, 28'd0} + 43'({s5_hl_reg, 1'b0}) + 43'(s5_ll_reg);
        s6_rk1_sum = s5_k1h_reg + s5_k1l_reg;
        s6_tx_next = ((s5_q1h_reg + s5_q1l_reg) <<< 1) + s5_txh_reg + s5_txl_reg;
        s6_ty_next = ((s5_q2h_reg + s5_q2l_reg) <<< 1) + s5_tyh_reg + s5_tyl_reg;

        // r^2 * k2
        s7_k2h_next = $signed({1'b0, s6_r2_reg[42:28]}) * cfg.radial_k2;
        s7_k2l_full = $signed({1'b0, s6_r2_reg[27:0]}) * cfg.radial_k2;

        // radial gain
        s8_f_next = F_ONE + s7_rk1_reg + s7_k2h_reg + s7_k2l_reg;

        // gain times normalized position
        s9_fxh_next = $signed(s8_f_reg[47:28]) * s8_xn_reg;
        s9_fyh_next = $signed(s8_f_reg[47:28]) * s8_yn_reg;
        s9_fxl_full = $signed({1'b0, s8_f_reg[27:0]}) * s8_xn_reg;
        s9_fyl_full = $signed({1'b0, s8_f_reg[27:0]}) * s8_yn_reg;

        s10_xd_next = s9_fxh_reg + s9_fxl_reg + s9_tx_reg;
        s10_yd_next = s9_fyh_reg + s9_fyl_reg + s9_ty_reg;

        // back to pixels
        s11_xph_next = $signed({1'b0, cfg.focal_length}) * $signed(s10_xd_reg[51:28]);
        s11_yph_next = $signed({1'b0, cfg.focal_length}) * $signed(s10_yd_reg[51:28]);
        s11_xpl_next = cfg.focal_length * s10_xd_reg[27:0];
        s11_ypl_next = cfg.focal_length * s10_yd_reg[27:0];

        // integer part of the destination; fraction stays in the low product
        s12_vx = $signed({1'b0, cfg.center_col}) + s11_xph_reg
               + $signed({1'b0, s11_xpl_reg[39:28]});
        s12_vy = $signed({1'b0, cfg.center_row}) + s11_yph_reg
               + $signed({1'b0, s11_ypl_reg[39:28]});
        s12_ok = !s12_vx[37] && (s12_vx != '0 || s11_xpl_reg[27:0] != '0)
              && (s12_vx < W_LIM)
              && !s12_vy[37] && (s12_vy != '0 || s11_ypl_reg[27:0] != '0)
              && (s12_vy < H_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_px_reg <= s1_px_next;
            s1_py_reg <= s1_py_next;
        end
        if (en[1])
        begin
            s2_xn_reg <= sat_q(s1_px_reg);
            s2_yn_reg <= sat_q(s1_py_reg);
        end
        if (en[2])
        begin
            s3_xx_reg <= s3_xx_full[62:28];
            s3_yy_reg <= s3_yy_full[62:28];
            s3_xy_reg <= $signed(s3_xy_full[63:28]);
            s3_xn_reg <= s2_xn_reg;
            s3_yn_reg <= s2_yn_reg;
        end
        if (en[3])
        begin
            s4_r_reg  <= s4_r_next;
            s4_rx_reg <= s4_rx_next;
            s4_ry_reg <= s4_ry_next;
            s4_xy_reg <= s3_xy_reg;
            s4_xn_reg <= s3_xn_reg;
            s4_yn_reg <= s3_yn_reg;
        end
        if (en[4])
        begin
            s5_hh_reg  <= s5_hh_next;
            s5_hl_reg  <= s5_hl_next;
            s5_ll_reg  <= s5_ll_full[55:28];
            s5_k1h_reg <= s5_k1h_next;
            s5_k1l_reg <= $signed(s5_k1l_full[60:28]);
            s5_q1h_reg <= s5_q1h_next;
            s5_q1l_reg <= $signed(s5_q1l_full[60:28]);
            s5_q2h_reg <= s5_q2h_next;
            s5_q2l_reg <= $signed(s5_q2l_full[60:28]);
            s5_txh_reg <= s5_txh_next;
            s5_txl_reg <= $signed(s5_txl_full[60:28]);
            s5_tyh_reg <= s5_tyh_next;
            s5_tyl_reg <= $signed(s5_tyl_full[60:28]);
            s5_xn_reg  <= s4_xn_reg;
            s5_yn_reg  <= s4_yn_reg;
        end
        if (en[5])
        begin
            s6_r2_reg  <= s6_r2_next;
            s6_rk1_reg <= $signed(s6_rk1_sum[39:0]);
            s6_tx_reg  <= s6_tx_next;
            s6_ty_reg  <= s6_ty_next;
            s6_xn_reg  <= s5_xn_reg;
            s6_yn_reg  <= s5_yn_reg;
        end
        if (en[6])
        begin
            s7_k2h_reg <= s7_k2h_next;
            s7_k2l_reg <= $signed(s7_k2l_full[60:28]);
            s7_rk1_reg <= s6_rk1_reg;
            s7_tx_reg  <= s6_tx_reg;
            s7_ty_reg  <= s6_ty_reg;
            s7_xn_reg  <= s6_xn_reg;
            s7_yn_reg  <= s6_yn_reg;
        end
        if (en[7])
        begin
            s8_f_reg  <= s8_f_next;
            s8_tx_reg <= s7_tx_reg;
            s8_ty_reg <= s7_ty_reg;
            s8_xn_reg <= s7_xn_reg;
            s8_yn_reg <= s7_yn_reg;
        end
        if (en[8])
        begin
            s9_fxh_reg <= s9_fxh_next;
            s9_fyh_reg <= s9_fyh_next;
            s9_fxl_reg <= $signed(s9_fxl_full[60:28]);
            s9_fyl_reg <= $signed(s9_fyl_full[60:28]);
            s9_tx_reg  <= s8_tx_reg;
            s9_ty_reg  <= s8_ty_reg;
        end
        if (en[9])
        begin
            s10_xd_reg <= s10_xd_next;
            s10_yd_reg <= s10_yd_next;
        end
        if (en[10])
        begin
            s11_xph_reg <= s11_xph_next;
            s11_yph_reg <= s11_yph_next;
            s11_xpl_reg <= s11_xpl_next;
            s11_ypl_reg <= s11_ypl_next;
        end
        if (en[11])
        begin
            dest_col_reg  <= s12_ok ? s12_vx[11:0] : 12'd0;
            dest_row_reg  <= s12_ok ? s12_vy[11:0] : 12'd0;
            in_bounds_reg <= s12_ok;
        end
    end

    assign dest_col  = dest_col_reg;
    assign dest_row  = dest_row_reg;
    assign in_bounds = in_bounds_reg;
    assign pix_out   = pix_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe stalls input with empty output stage");

    a_drain_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready)
        else $error("pipe stalls input while output drains");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word missing from first stage");

    a_dest_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_bounds) |->
            (dest_col < 12'(IMAGE_WIDTH)) && (dest_row < 12'(IMAGE_HEIGHT)))
        else $error("in-bounds destination outside image");

    a_dest_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_bounds) |-> (dest_col == 12'd0) && (dest_row == 12'd0))
        else $error("out-of-bounds destination not cleared");

endmodule

@@ hw/rtl/lens_distortion_pixel_remap.sv @@
// Top level of the lens distortion pixel remapper: configuration registers and pipeline.
//
//   channel  direction  handshake               payload
//   -------  ---------  ----------------------  -----------------------------------------
//   cfg      in         cfg_wr_en (no wait)     cfg_index[2:0], cfg_data[31:0]
//   in       in         in_valid / in_ready     src_col, src_row, red, green, blue
//   out      out        out_valid / out_ready   dest_col, dest_row, out_red/green/blue,
//                                               in_bounds
//
// One word per clock enters and leaves while out_ready does not stall the pipe; the
// words pass register stages: normalize, square, radius, r^2 and coefficient
// products, radial gain, gain times position, focal scaling and the bounds test.
// Reset loads the default lens registers and clears every stage valid bit; no
// memory needs clearing, so the block takes words right after reset.
// Each stage holds its word while the next stage is full and stalled, so a stall
// at the output backs up stage by stage and empty stages keep filling.
module lens_distortion_pixel_remap #(
    parameter int unsigned IMAGE_WIDTH  = ldpr_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = ldpr_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // source pixel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] src_col,
    input  logic [11:0] src_row,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // remapped pixel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] dest_col,
    output logic [11:0] dest_row,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        in_bounds
);

    ldpr_pkg::cfg_t cfg_reg;
    ldpr_pkg::cfg_t cfg_next;
    ldpr_pkg::rgb_t pix_in;
    ldpr_pkg::rgb_t pix_out;

    // Decode the register write. Writes must only happen while the pipe is idle; the
    // block does not enforce this, and every stage reads these registers directly.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (ldpr_pkg::cfg_idx_t'(cfg_index))
                ldpr_pkg::CFG_CENTER_COL: cfg_next.center_col    = cfg_data[11:0];
                ldpr_pkg::CFG_CENTER_ROW: cfg_next.center_row    = cfg_data[11:0];
                ldpr_pkg::CFG_FOCAL_LEN:  cfg_next.focal_length  = cfg_data[11:0];
                ldpr_pkg::CFG_NORM_SCALE: cfg_next.norm_scale    = cfg_data[23:0];
                ldpr_pkg::CFG_RADIAL_K1:  cfg_next.radial_k1     = $signed(cfg_data);
                ldpr_pkg::CFG_RADIAL_K2:  cfg_next.radial_k2     = $signed(cfg_data);
                ldpr_pkg::CFG_TAN_P1:     cfg_next.tangential_p1 = $signed(cfg_data);
                ldpr_pkg::CFG_TAN_P2:     cfg_next.tangential_p2 = $signed(cfg_data);
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ldpr_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Bundle the colour bytes so they travel as one word down the pipe
    assign pix_in.red   = red;
    assign pix_in.green = green;
    assign pix_in.blue  = blue;

    ldpr_pipe #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .src_col   (src_col),
        .src_row   (src_row),
        .pix_in    (pix_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dest_col  (dest_col),
        .dest_row  (dest_row),
        .pix_out   (pix_out),
        .in_bounds (in_bounds)
    );

    assign out_red   = pix_out.red;
    assign out_green = pix_out.green;
    assign out_blue  = pix_out.blue;

endmodule
